@@ src/hng_pkg.sv @@
// Package for the heightmap normal generator: state codes, register
// indexes and fixed field widths. No dependencies.
`default_nettype none
package hng_pkg;

  // fixed field widths
  localparam int HEIGHT_BITS = 16;
  localparam int CNT_BITS    = 12;   // row/column counters, hold any width up to 4095
  localparam int POS_BITS    = 11;   // row/col output fields
  localparam int NRM_BITS    = 16;
  localparam int NRMY_BITS   = 15;
  localparam int ACC_BITS    = 68;   // normalizer accumulators
  localparam int LEN_BITS    = 34;   // squared vector length
  localparam int SCALE_MSB   = 14;   // top bit of a unit-scaled magnitude

  localparam int MAX_WIDTH_DEF = 2048;

  // register indexes
  localparam logic REG_GRID_WIDTH   = 1'b0;
  localparam logic REG_GRID_SPACING = 1'b1;

  localparam logic [11:0] WIDTH_RESET   = 12'd2048;
  localparam logic [7:0]  SPACING_RESET = 8'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_DIFF,
    ST_SQ,
    ST_SUM,
    ST_ITER
  } state_e;

endpackage
`default_nettype wire

@@ src/heightmap_normal_generator_unit.sv @@
// Heightmap normal generator top level: line stores, window and normalizer.
// Depends on hng_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_stall_o | height_i, grid_start_i
//  out     | output    | out_valid_o / out_stall_i | row_o, col_o, normal_x/y/z_o
//  cfg     | input     | APB psel/penable/pready | grid_width (0x0), grid_spacing (0x4)
//
// A sample that yields no normal passes through the accept and line-store read
// states, with one more read state at column 0, where two line-store reads are
// needed. An interior point goes on through difference, squaring and length,
// the normalizer, one result bit at a time, and a load of the output register.
// Reset clears counters and window; line stores are not cleared.
// A result waits in the output register; the next request is taken meanwhile,
// and a new result waits for the register to be freed.
`default_nettype none
module heightmap_normal_generator_unit #(
  parameter int MAX_WIDTH = hng_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [hng_pkg::HEIGHT_BITS-1:0] height_i,
  input  wire logic                                grid_start_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [hng_pkg::POS_BITS-1:0]             row_o,
  output logic [hng_pkg::POS_BITS-1:0]             col_o,
  output logic signed [hng_pkg::NRM_BITS-1:0]      normal_x_o,
  output logic [hng_pkg::NRMY_BITS-1:0]            normal_y_o,
  output logic signed [hng_pkg::NRM_BITS-1:0]      normal_z_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WMAX_I = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
  localparam logic [hng_pkg::CNT_BITS-1:0] WMAX = hng_pkg::CNT_BITS'(WMAX_I);
  localparam int CW = hng_pkg::CNT_BITS;
  localparam int HB = hng_pkg::HEIGHT_BITS;
  localparam int AB = hng_pkg::ACC_BITS;
  localparam int SCALE_W = hng_pkg::SCALE_MSB + 1;

  // ---------------- configuration registers
  logic [11:0] cfg_width_q;
  logic [7:0]  cfg_spacing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q   <= hng_pkg::WIDTH_RESET;
      cfg_spacing_q <= hng_pkg::SPACING_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == hng_pkg::REG_GRID_WIDTH) cfg_width_q <= pwdata[11:0];
      else                                     cfg_spacing_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == hng_pkg::REG_GRID_WIDTH) prdata = {20'd0, cfg_width_q};
    else                                     prdata = {24'd0, cfg_spacing_q};
  end

  // effective width
  logic [CW-1:0] w_eff;
  always_comb begin
    w_eff = cfg_width_q;
    if (cfg_width_q < 12'd3) w_eff = 12'd3;
    if (cfg_width_q > WMAX)  w_eff = WMAX;
  end

  // ---------------- control state
  hng_pkg::state_e state_q, state_d;
  logic            done_q;   // normalizer finished, result awaiting output register

  logic [CW-1:0]         row_cnt_q, col_cnt_q;
  logic [CW-1:0]         r_q, c_q, w_q;
  logic signed [HB-1:0]  h_q, down_q;
  logic signed [HB-1:0]  win_q [3];
  logic                  emit_q;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // position of this sample
  logic [CW-1:0] r_pos, c_pos;
  logic [CW:0]   r_inc;
  always_comb begin
    r_inc = {1'b0, row_cnt_q};
    c_pos = col_cnt_q;
    if (grid_start_i) begin
      r_inc = '0;
      c_pos = '0;
    end else if (col_cnt_q >= w_eff) begin
      c_pos = '0;
      r_inc = {1'b0, row_cnt_q} + 1'b1;
    end
    r_pos = (r_inc >= {1'b0, w_eff}) ? '0 : r_inc[CW-1:0];
  end

  // ---------------- line stores
  logic [HB-1:0] older_mem [MAX_WIDTH];
  logic [HB-1:0] newer_mem [MAX_WIDTH];
  logic [HB-1:0] older_rd_q, newer_rd_q;
  logic [AW-1:0] cur_addr, mid_addr, older_ra, newer_ra;
  logic [CW:0]   c_plus1;
  logic          cur_we;

  assign c_plus1  = {1'b0, c_q} + 1'b1;
  assign cur_addr = c_q[AW-1:0];
  always_comb begin
    mid_addr = c_plus1[AW-1:0];
    if (state_q == hng_pkg::ST_RD0 && c_q == '0) mid_addr = '0;
    if (state_q == hng_pkg::ST_RD1) mid_addr = AW'(1);
  end
  assign older_ra = r_q[0] ? mid_addr : cur_addr;
  assign newer_ra = r_q[0] ? cur_addr : mid_addr;

  always_ff @(posedge clk_i) begin
    if (cur_we && !r_q[0]) older_mem[cur_addr] <= h_q;
    older_rd_q <= older_mem[older_ra];
  end
  always_ff @(posedge clk_i) begin
    if (cur_we && r_q[0]) newer_mem[cur_addr] <= h_q;
    newer_rd_q <= newer_mem[newer_ra];
  end

  logic signed [HB-1:0] cur_rd, mid_rd;
  assign cur_rd = r_q[0] ? newer_rd_q : older_rd_q;
  assign mid_rd = r_q[0] ? older_rd_q : newer_rd_q;

  // emit test for the current sample
  logic emit_now;
  assign emit_now = (r_q >= 12'd2) && (c_q >= 12'd1) &&
                    (({1'b0, c_q} + 2'd2) <= {1'b0, w_q});

  // ---------------- normalizer datapath
  logic signed [HB:0]          dh_q, dv_q;
  logic                        neg_x_q, neg_z_q;   // output sign negative
  logic [12:0]                 t_q;
  logic [2*HB-1:0]             sq_q [3];
  logic [hng_pkg::LEN_BITS-1:0] len2_q, len2_d;
  logic signed [AB-1:0]        a_q [3];
  logic signed [AB-1:0]        b_q [3];
  logic [SCALE_W-1:0]          v_q [3];
  logic [3:0]                  bit_q;

  logic signed [AB-1:0] lsig, lsig_d, a_try [3], r_lim [3];
  logic                 fits [3];
  logic [5:0]           sh1, sh2, sh0;
  assign len2_d = hng_pkg::LEN_BITS'(sq_q[0]) + hng_pkg::LEN_BITS'(sq_q[1]) +
                  hng_pkg::LEN_BITS'(sq_q[2]);
  assign lsig_d = AB'(signed'({1'b0, len2_d}));
  assign lsig = AB'(signed'({1'b0, len2_q}));
  assign sh0  = {2'b00, bit_q} + 6'd1;
  assign sh1  = {2'b00, bit_q} + 6'd2;
  assign sh2  = {1'b0, bit_q, 1'b0} + 6'd2;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_lim[i] = AB'(signed'({1'b0, sq_q[i]})) <<< 30;
      a_try[i] = a_q[i] + (b_q[i] <<< sh1) + (lsig <<< sh2);
      fits[i]  = a_try[i] <= r_lim[i];
    end
  end

  logic [16:0] mx_abs, mz_abs;
  assign mx_abs = dh_q[HB] ? 17'(-dh_q) : 17'(dh_q);
  assign mz_abs = dv_q[HB] ? 17'(-dv_q) : 17'(dv_q);

  // ---------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hng_pkg::ST_IDLE: if (in_acc) state_d = hng_pkg::ST_RD0;
      hng_pkg::ST_RD0:  state_d = hng_pkg::ST_RD1;
      hng_pkg::ST_RD1: begin
        if (c_q == '0)     state_d = hng_pkg::ST_RD2;
        else if (emit_now) state_d = hng_pkg::ST_DIFF;
        else               state_d = hng_pkg::ST_IDLE;
      end
      hng_pkg::ST_RD2:  state_d = emit_q ? hng_pkg::ST_DIFF : hng_pkg::ST_IDLE;
      hng_pkg::ST_DIFF: state_d = hng_pkg::ST_SQ;
      hng_pkg::ST_SQ:   state_d = hng_pkg::ST_SUM;
      hng_pkg::ST_SUM:  state_d = hng_pkg::ST_ITER;
      hng_pkg::ST_ITER: begin
        if (done_q && (!out_valid_o || !out_stall_i)) state_d = hng_pkg::ST_IDLE;
      end
      default: state_d = hng_pkg::ST_IDLE;
    endcase
  end

  // ---------------- control outputs
  always_comb begin
    in_stall_o = (state_q != hng_pkg::ST_IDLE);
    cur_we     = (state_q == hng_pkg::ST_RD1);
  end

  logic load_out;
  assign load_out = (state_q == hng_pkg::ST_ITER) && done_q &&
                    (!out_valid_o || !out_stall_i);

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hng_pkg::ST_IDLE;
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      for (int i = 0; i < 3; i++) win_q[i] <= '0;
      out_valid_o <= 1'b0;
      done_q    <= 1'b0;
      bit_q     <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (({1'b0, c_pos} + 1'b1) >= {1'b0, w_eff}) begin
          col_cnt_q <= '0;
          row_cnt_q <= (({1'b0, r_pos} + 1'b1) >= {1'b0, w_eff}) ? '0 : r_pos + 1'b1;
        end else begin
          col_cnt_q <= c_pos + 1'b1;
          row_cnt_q <= r_pos;
        end
      end
      // middle-row window
      if (state_q == hng_pkg::ST_RD1) begin
        if (c_q == '0) begin
          win_q[0] <= '0;
          win_q[1] <= mid_rd;
        end else begin
          win_q[0] <= win_q[1];
          win_q[1] <= win_q[2];
          win_q[2] <= (c_plus1 < {1'b0, w_q}) ? mid_rd : '0;
        end
      end
      if (state_q == hng_pkg::ST_RD2) win_q[2] <= mid_rd;
      // normalizer sequencing
      if (state_q == hng_pkg::ST_SUM) begin
        bit_q  <= 4'(hng_pkg::SCALE_MSB);
        done_q <= 1'b0;
      end else if (state_q == hng_pkg::ST_ITER && !done_q) begin
        if (bit_q == '0) done_q <= 1'b1;
        else             bit_q  <= bit_q - 1'b1;
      end
      if (load_out)                     out_valid_o <= 1'b1;
      else if (!out_stall_i)            out_valid_o <= 1'b0;
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r_q <= r_pos;
      c_q <= c_pos;
      w_q <= w_eff;
      h_q <= height_i;
    end
    if (state_q == hng_pkg::ST_RD1) begin
      down_q <= cur_rd;
      emit_q <= emit_now;
    end
    // differences
    if (state_q == hng_pkg::ST_DIFF) begin
      dh_q <= (HB+1)'(win_q[2]) - (HB+1)'(win_q[0]);
      dv_q <= (HB+1)'(h_q) - (HB+1)'(down_q);
      t_q  <= {(cfg_spacing_q == '0) ? 8'd1 : cfg_spacing_q, 5'd0};
    end
    // magnitudes and squares
    if (state_q == hng_pkg::ST_SQ) begin
      neg_x_q <= !dh_q[HB] && (dh_q != '0);
      neg_z_q <= !dv_q[HB] && (dv_q != '0);
      sq_q[0] <= mx_abs[HB-1:0] * mx_abs[HB-1:0];
      sq_q[1] <= 32'(t_q) * 32'(t_q);
      sq_q[2] <= mz_abs[HB-1:0] * mz_abs[HB-1:0];
    end
    // length and normalizer start: v = 0, A = (2v-1)^2*L, B = (2v-1)*L
    if (state_q == hng_pkg::ST_SUM) begin
      len2_q <= len2_d;
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= '0;
        a_q[i] <= lsig_d;
        b_q[i] <= -lsig_d;
      end
    end
    // one result bit per lane per cycle
    if (state_q == hng_pkg::ST_ITER && !done_q) begin
      for (int i = 0; i < 3; i++) begin
        if (fits[i]) begin
          v_q[i] <= v_q[i] | (SCALE_W'(1) << bit_q);
          a_q[i] <= a_try[i];
          b_q[i] <= b_q[i] + (lsig <<< sh0);
        end
      end
    end
    if (load_out) begin
      row_o      <= hng_pkg::POS_BITS'(r_q - 1'b1);
      col_o      <= hng_pkg::POS_BITS'(c_q);
      normal_x_o <= neg_x_q ? -hng_pkg::NRM_BITS'(v_q[0]) : hng_pkg::NRM_BITS'(v_q[0]);
      normal_y_o <= hng_pkg::NRMY_BITS'(v_q[1]);
      normal_z_o <= neg_z_q ? -hng_pkg::NRM_BITS'(v_q[2]) : hng_pkg::NRM_BITS'(v_q[2]);
    end
  end

  // ---------------- assertions
  a_out_from_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == hng_pkg::ST_ITER && $past(done_q))
    else $error("result appeared without a finished normalization");
  a_up_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_y_o != '0)
    else $error("up component of a normal is zero");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(normal_x_o))
    else $error("pending result was overwritten");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request taken while the previous one is in progress");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for heightmap_normal_generator_unit: streams height samples, predicts
// the emitted unit normals in a scoreboard class, checks every result in order.
// Depends on hng_pkg and the heightmap_normal_generator_unit RTL.
`default_nettype none

typedef struct {
  logic [10:0]        row;
  logic [10:0]        col;
  logic signed [15:0] nx;
  logic [14:0]        ny;
  logic signed [15:0] nz;
} normal_t;

class normal_scoreboard;
  normal_t            pending_normals[$];
  int                 fails;
  int unsigned        width_reg;
  int unsigned        spacing_reg;
  bit signed [15:0]   line_store[2][2048];
  longint             win[3];
  int unsigned        row_cnt;
  int unsigned        col_cnt;

  function new();
    fails = 0;
    width_reg = 2048;
    spacing_reg = 8;
    row_cnt = 0;
    col_cnt = 0;
    foreach (win[i]) win[i] = 0;
  endfunction

  function void set_reg(logic idx, int unsigned val);
    if (idx == hng_pkg::REG_GRID_WIDTH) width_reg = val & 12'hFFF;
    else spacing_reg = val & 8'hFF;
  endfunction

  // round(m * 2^14 / sqrt(len2)), halves up
  function int unsigned unit_mag(longint unsigned m, bit [127:0] len2);
    bit [127:0]  rhs;
    bit [127:0]  k;
    int unsigned lo, hi, md;
    rhs = (128'(m) * 128'(m)) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      md = (lo + hi + 1) >> 1;
      k = 128'(2 * md - 1) * 128'(2 * md - 1);
      if (k * len2 <= rhs) lo = md;
      else hi = md - 1;
    end
    return lo;
  endfunction

  // advance the stencil by one accepted request, queue any normal it yields
  function void note_request(logic signed [15:0] h, logic gs);
    int unsigned      w, r, c, cur, midr, t;
    longint           dh, dv, down;
    longint unsigned  mx, mz;
    bit [127:0]       len2;
    normal_t          e;
    int unsigned      mag;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > 2048) w = 2048;
    r = row_cnt;
    c = col_cnt;
    if (gs) begin
      r = 0;
      c = 0;
    end else if (c >= w) begin
      c = 0;
      r = r + 1;
    end
    if (r >= w) r = 0;
    cur = r & 1;
    midr = 1 - cur;
    if (c == 0) begin
      win[0] = 0;
      win[1] = line_store[midr][0];
      win[2] = line_store[midr][1];
    end else begin
      win[0] = win[1];
      win[1] = win[2];
      win[2] = (c + 1 < w) ? longint'(line_store[midr][c+1]) : 0;
    end
    down = line_store[cur][c];
    if (r >= 2 && c >= 1 && c + 2 <= w) begin
      dh = win[2] - win[0];
      dv = longint'(h) - down;
      mx = dh < 0 ? -dh : dh;
      mz = dv < 0 ? -dv : dv;
      t = 32 * (spacing_reg == 0 ? 1 : spacing_reg);
      len2 = 128'(mx) * mx + 128'(mz) * mz + 128'(t) * t;
      e.row = 11'(r - 1);
      e.col = 11'(c);
      mag = unit_mag(mx, len2);
      e.nx = (dh > 0) ? -16'(mag) : 16'(mag);
      e.ny = 15'(unit_mag(t, len2));
      mag = unit_mag(mz, len2);
      e.nz = (dv > 0) ? -16'(mag) : 16'(mag);
      pending_normals.insert(pending_normals.size(), e);
    end
    line_store[cur][c] = h;
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= w) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endfunction

  function void check_result(normal_t got);
    normal_t e;
    if (pending_normals.size() == 0) begin
      $display("%0t: unexpected normal row %0d col %0d", $time, got.row, got.col);
      fails++;
      return;
    end
    e = pending_normals.pop_front();
    if (got.row !== e.row) begin
      $display("%0t: row expected %0d actual %0d", $time, e.row, got.row);
      fails++;
    end
    if (got.col !== e.col) begin
      $display("%0t: col expected %0d actual %0d", $time, e.col, got.col);
      fails++;
    end
    if (got.nx !== e.nx) begin
      $display("%0t: normal_x expected %0d actual %0d", $time, e.nx, got.nx);
      fails++;
    end
    if (got.ny !== e.ny) begin
      $display("%0t: normal_y expected %0d actual %0d", $time, e.ny, got.ny);
      fails++;
    end
    if (got.nz !== e.nz) begin
      $display("%0t: normal_z expected %0d actual %0d", $time, e.nz, got.nz);
      fails++;
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RND_ITEMS   = 1430;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] height_i = '0;
  logic               grid_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [10:0]        row_o, col_o;
  logic signed [15:0] normal_x_o, normal_z_o;
  logic [14:0]        normal_y_o;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  normal_scoreboard sb = new();
  bit               quiet = 1'b0;
  int               holds_asked = 0;
  int               holds_done = 0;
  int               hold_left = 0;
  int               stall_burst = 0;
  longint           cycles = 0;

  heightmap_normal_generator_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .height_i, .grid_start_i,
    .out_valid_o, .out_stall_i, .row_o, .col_o, .normal_x_o, .normal_y_o,
    .normal_z_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    normal_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.row = row_o;
      got.col = col_o;
      got.nx = normal_x_o;
      got.ny = normal_y_o;
      got.nz = normal_z_o;
      sb.check_result(got);
    end
  end

  // receiver stalls: random, with bursts and requested long holds
  always @(posedge clk_i) begin
    int p;
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked > holds_done) begin
      out_stall_i <= 1'b1;
      hold_left <= 400;
      holds_done <= holds_done + 1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_burst > 0) begin
      out_stall_i <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 2) stall_burst <= $urandom_range(20, 60);
      out_stall_i <= (p < 15);
    end
  end

  task automatic apb_write(logic idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // wait for all normals, then let the normalizer drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_normals.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned w, int unsigned sp);
    drain();
    apb_write(hng_pkg::REG_GRID_WIDTH, w);
    apb_write(hng_pkg::REG_GRID_SPACING, sp);
  endtask

  task automatic send(logic signed [15:0] h, logic gs);
    int gap, p;
    gap = 0;
    if (!quiet) begin
      p = $urandom_range(0, 99);
      if (p < 3) gap = $urandom_range(15, 50);
      else if (p < 25) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    height_i <= h;
    grid_start_i <= gs;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(h, gs);
  endtask

  function automatic logic signed [15:0] pick_height(int style, logic signed [15:0] base);
    if (style == 0) return 16'($urandom);
    return base + 16'($signed($urandom_range(0, 511)) - 256);
  endfunction

  initial begin
    int w, n, grids, style, rnd_items;
    logic signed [15:0] base;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest grid, steepest slopes, minimum spacing (zero acts as one)
    configure(0, 0);
    send(16'sh7FFF, 1'b1); send(16'sh8000, 1'b0); send(16'sh7FFF, 1'b0);
    send(16'sh8000, 1'b0); send(16'sh0000, 1'b0); send(16'sh7FFF, 1'b0);
    send(16'sh8000, 1'b0); send(16'sh7FFF, 1'b0); send(16'sh8000, 1'b0);
    // flat grid at maximum spacing, then row wrap into a second grid;
    // the receiver holds off meanwhile so the block backs up
    configure(4, 255);
    holds_asked++;
    for (int i = 0; i < 24; i++) send(16'sh0100, i == 0);
    // width lowered mid-row: sample past the width starts the next row
    configure(10, 1);
    for (int i = 0; i < 28; i++) send(16'($urandom), i == 0);
    configure(5, 1);
    for (int i = 0; i < 15; i++) send(16'($urandom), 1'b0);
    // oversized width register clamps to the maximum: first row only
    configure(4095, 8);
    for (int i = 0; i < 40; i++) send(16'($urandom_range(0, 4095)), i == 0);

    // random phases of whole grids with occasional noise
    rnd_items = 0;
    while (rnd_items < RND_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      configure(($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : w,
                $urandom_range(0, 255));
      if (sb.width_reg < 3) w = 3;
      quiet = ($urandom_range(0, 4) == 0);
      if (rnd_items == 0) holds_asked++;
      grids = $urandom_range(1, 3);
      for (int g = 0; g < grids; g++) begin
        style = $urandom_range(0, 2);
        base = 16'($urandom);
        n = w * w;
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
        for (int i = 0; i < n; i++) begin
          if (rnd_items >= RND_ITEMS) break;
          base = pick_height(style, base);
          send(base, (i == 0) || ($urandom_range(0, 199) == 0));
          rnd_items++;
        end
      end
    end
    quiet = 1'b0;

    drain();
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
